// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define RRS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/rrs_pkg.sv =====
// types, constants and helpers shared by the round-robin scheduler
package rrs_pkg;

    localparam int TASK_W  = 4;
    localparam int SLICE_W = 8;
    localparam int Q_DEPTH = 16;
    localparam int Q_PTR_W = 4;

    // queue holds at most one entry less than its depth
    localparam logic [Q_PTR_W-1:0] Q_CAP = Q_PTR_W'(Q_DEPTH - 1);

    localparam logic [TASK_W-1:0]  IDLE_ID       = '0;
    localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 8'd5;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SCHED = 2'd1,
        OP_WAKE  = 2'd2
    } rrs_op_t;

    // ready queue control from the scheduler core
    typedef struct packed {
        logic              push;
        logic [TASK_W-1:0] push_id;
        logic              pop;
    } rrs_q_ctrl_t;

    // ready queue status toward the scheduler core
    typedef struct packed {
        logic [TASK_W-1:0]  head;
        logic [Q_PTR_W-1:0] count;
    } rrs_q_stat_t;

    // per-task table write request
    typedef struct packed {
        logic               slice_we;
        logic               run_we;
        logic               run_val;
        logic [TASK_W-1:0]  id;
        logic [SLICE_W-1:0] slice_val;
    } rrs_tt_wr_t;

    // slice refill applied whenever a task enters the ready queue
    function automatic logic [SLICE_W-1:0] refill(input logic [SLICE_W-1:0] slice,
                                                  input logic [SLICE_W-1:0] max_slice);
        refill = ((slice == '0) || (slice > max_slice)) ? max_slice : slice;
    endfunction

endpackage

// ===== rtl/core/rrs_req_if.sv =====
// operation request channel
interface rrs_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [rrs_pkg::TASK_W-1:0] task_id;
    logic                      current_stays_runnable;

    modport source (output valid, output op, output task_id,
                    output current_stays_runnable, input ready);
    modport sink   (input valid, input op, input task_id,
                    input current_stays_runnable, output ready);
endinterface

// ===== rtl/core/rrs_rsp_if.sv =====
// scheduler result channel
interface rrs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rrs_pkg::TASK_W-1:0]  running_task;
    logic                        switched;
    logic                        resched_needed;
    logic [rrs_pkg::SLICE_W-1:0] slice_remaining;
    logic [rrs_pkg::Q_PTR_W-1:0] ready_count;
    logic                        wake_ignored;

    modport source (output valid, output running_task, output switched,
                    output resched_needed, output slice_remaining,
                    output ready_count, output wake_ignored, input ready);
    modport sink   (input valid, input running_task, input switched,
                    input resched_needed, input slice_remaining,
                    input ready_count, input wake_ignored, output ready);
endinterface

// ===== rtl/core/rrs_cfg_if.sv =====
// max slice configuration write channel
interface rrs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rrs_pkg::SLICE_W-1:0] max_slice;

    modport source (output valid, output max_slice, input ready);
    modport sink   (input valid, input max_slice, output ready);
endinterface

// ===== rtl/core/rrs_ready_queue.sv =====
// circular ready queue of task ids with head pointer and fill count
`include "assert_macros.svh"

module rrs_ready_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrs_pkg::rrs_q_ctrl_t ctrl,
    output rrs_pkg::rrs_q_stat_t stat
);

    logic [rrs_pkg::TASK_W-1:0]  ent_reg [rrs_pkg::Q_DEPTH];
    logic [rrs_pkg::Q_PTR_W-1:0] head_reg;
    logic [rrs_pkg::Q_PTR_W-1:0] head_next;
    logic [rrs_pkg::Q_PTR_W-1:0] count_reg;
    logic [rrs_pkg::Q_PTR_W-1:0] count_next;
    logic [rrs_pkg::Q_PTR_W-1:0] tail;

    // tail slot wraps around the queue depth
    assign tail = head_reg + count_reg;

    // pointer and count update
    always_comb
    begin
        head_next  = ctrl.pop ? head_reg + rrs_pkg::Q_PTR_W'(1) : head_reg;
        count_next = count_reg + rrs_pkg::Q_PTR_W'(ctrl.push)
                     - rrs_pkg::Q_PTR_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // entry storage, written at the tail
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            ent_reg[tail] <= ctrl.push_id;
        end
    end

    assign stat.head  = ent_reg[head_reg];
    assign stat.count = count_reg;

    `RRS_NEVER(a_push_full, ctrl.push && (count_reg >= rrs_pkg::Q_CAP), "push into full queue")
    `RRS_NEVER(a_pop_empty, ctrl.pop && (count_reg == '0) && !ctrl.push, "pop from empty queue")

endmodule

// ===== rtl/core/rrs_task_table.sv =====
// per-task runnable flags and saved time slices
`include "assert_macros.svh"

module rrs_task_table
#(
    parameter int NUM_TASKS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rrs_pkg::TASK_W-1:0]  rd_id,
    output logic [rrs_pkg::SLICE_W-1:0] rd_slice,
    output logic                        rd_runnable,
    input  rrs_pkg::rrs_tt_wr_t         wr
);

    // ids are TASK_W bits wide, so no more slots than that can address
    localparam int SLOTS = (NUM_TASKS < (2 ** rrs_pkg::TASK_W)) ?
                           NUM_TASKS : (2 ** rrs_pkg::TASK_W);
    localparam int IDX_W = $clog2(SLOTS);

    logic [rrs_pkg::SLICE_W-1:0] slice_reg [SLOTS];
    logic [SLOTS-1:0]            run_reg;
    logic [IDX_W-1:0]            rd_idx;
    logic [IDX_W-1:0]            wr_idx;
    logic                        rd_in;
    logic                        wr_in;
    logic [IDX_W-1:0]            idle_idx;

    assign rd_idx   = rd_id[IDX_W-1:0];
    assign wr_idx   = wr.id[IDX_W-1:0];
    assign rd_in    = 32'(rd_id) < SLOTS;
    assign wr_in    = 32'(wr.id) < SLOTS;
    assign idle_idx = rrs_pkg::IDLE_ID[IDX_W-1:0];

    // read port, out of range ids read as asleep with empty slice
    assign rd_slice    = rd_in ? slice_reg[rd_idx] : '0;
    assign rd_runnable = rd_in ? run_reg[rd_idx] : 1'b0;

    // table update, reset leaves only the idle task runnable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slice_reg[i] <= '0;
            end
            run_reg <= SLOTS'(1) << idle_idx;
        end
        else
        begin
            if (wr.slice_we && wr_in)
            begin
                slice_reg[wr_idx] <= wr.slice_val;
            end
            if (wr.run_we && wr_in)
            begin
                run_reg[wr_idx] <= wr.run_val;
            end
        end
    end

    `RRS_ASSERT(a_idle_runnable, run_reg[idle_idx], "idle task lost its runnable flag")

endmodule

// ===== rtl/core/round_robin_time_slice_scheduler_top.sv =====
// round-robin time-slice scheduler top level
//
// Channels: req carries one operation per transaction (op 0 tick, 1 schedule,
// 2 wake task_id; current_stays_runnable is used by schedule). rsp returns
// exactly one result transaction per request: running task, switched flag,
// reschedule flag, remaining slice of the running task, ready queue fill and
// the wake-ignored flag, all giving the state after the operation. cfg writes
// max_slice, the slice handed to a task as it is queued; it is always ready
// and should only be written while no operation is outstanding.
// Path: an accepted request is held in the request register, worked on by the
// update path and registered in the result register, from which it shows on rsp.
// Throughput: one operation per cycle while rsp is taken; the single update path
// between request register and result register does all queue and table work.
// Reset: the queue is empty, only the idle task is runnable and running, all
// slices are zero, the reschedule flag is clear and max_slice is 5.
// A stalled rsp holds its result; one more request is held in the request
// register, after which req.ready drops until rsp is taken.
`include "assert_macros.svh"

module round_robin_time_slice_scheduler_top
#(
    parameter int NUM_TASKS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    rrs_req_if.sink        req,
    rrs_rsp_if.source      rsp,
    rrs_cfg_if.sink        cfg
);

    // request register
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [1:0]                  s1_op_reg;
    logic [rrs_pkg::TASK_W-1:0]  s1_tid_reg;
    logic                        s1_stays_reg;

    // scheduler state
    logic [rrs_pkg::TASK_W-1:0]  cur_task_reg;
    logic [rrs_pkg::TASK_W-1:0]  cur_task_next;
    logic [rrs_pkg::SLICE_W-1:0] cur_slice_reg;
    logic [rrs_pkg::SLICE_W-1:0] cur_slice_next;
    logic                        resched_reg;
    logic                        resched_next;
    logic [rrs_pkg::SLICE_W-1:0] max_slice_reg;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rrs_pkg::TASK_W-1:0]  out_task_reg;
    logic                        out_switched_reg;
    logic                        out_resched_reg;
    logic [rrs_pkg::SLICE_W-1:0] out_slice_reg;
    logic [rrs_pkg::Q_PTR_W-1:0] out_count_reg;
    logic                        out_ignored_reg;

    // update path
    logic                        adv;
    logic                        req_fire;
    rrs_pkg::rrs_q_ctrl_t        q_ctrl;
    rrs_pkg::rrs_q_stat_t        q_stat;
    rrs_pkg::rrs_tt_wr_t         tt_wr;
    logic [rrs_pkg::TASK_W-1:0]  tt_rd_id;
    logic [rrs_pkg::SLICE_W-1:0] tt_rd_slice;
    logic                        tt_rd_run;
    logic                        requeue;
    logic                        pop_any;
    logic [rrs_pkg::TASK_W-1:0]  cand;
    logic [rrs_pkg::TASK_W-1:0]  pick_task;
    logic [rrs_pkg::SLICE_W-1:0] wb_slice;
    logic [rrs_pkg::SLICE_W-1:0] dec_slice;
    logic                        wake_ok;
    logic                        switched;
    logic                        ignored;
    logic [rrs_pkg::Q_PTR_W-1:0] count_next;

    rrs_ready_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    rrs_task_table #(.NUM_TASKS(NUM_TASKS)) u_tasks
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_id       (tt_rd_id),
        .rd_slice    (tt_rd_slice),
        .rd_runnable (tt_rd_run),
        .wr          (tt_wr)
    );

    // handshake and stage advance
    assign adv           = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready     = !s1_valid_reg || adv;
    assign req_fire      = req.valid && req.ready;
    assign s1_valid_next = req_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    assign cfg.ready     = 1'b1;

    // helpers: requeue the running task, pick the queue head or idle, tick and wake checks
    always_comb
    begin
        requeue = (cur_task_reg != rrs_pkg::IDLE_ID) && s1_stays_reg
                  && (q_stat.count < rrs_pkg::Q_CAP);
        pop_any = (q_stat.count != '0) || requeue;
        cand    = (q_stat.count == '0) ? cur_task_reg : q_stat.head;
        pick_task = (pop_any && (32'(cand) < NUM_TASKS)) ? cand : rrs_pkg::IDLE_ID;
        wb_slice  = requeue ? rrs_pkg::refill(cur_slice_reg, max_slice_reg) : cur_slice_reg;
        dec_slice = (cur_slice_reg != '0) ? cur_slice_reg - rrs_pkg::SLICE_W'(1)
                                          : cur_slice_reg;
        tt_rd_id  = (s1_op_reg == rrs_pkg::OP_WAKE) ? s1_tid_reg : pick_task;
        wake_ok   = (32'(s1_tid_reg) < NUM_TASKS) && (s1_tid_reg != rrs_pkg::IDLE_ID)
                    && (s1_tid_reg != cur_task_reg) && !tt_rd_run
                    && (q_stat.count < rrs_pkg::Q_CAP);
    end

    // operation decode and state update
    always_comb
    begin
        q_ctrl         = '0;
        tt_wr          = '0;
        cur_task_next  = cur_task_reg;
        cur_slice_next = cur_slice_reg;
        resched_next   = resched_reg;
        switched       = 1'b0;
        ignored        = 1'b0;
        if (adv)
        begin
            unique case (s1_op_reg)
                rrs_pkg::OP_TICK:
                begin
                    cur_slice_next = dec_slice;
                    resched_next   = resched_reg || (dec_slice == '0);
                end
                rrs_pkg::OP_SCHED:
                begin
                    resched_next    = 1'b0;
                    q_ctrl.push     = requeue;
                    q_ctrl.push_id  = cur_task_reg;
                    q_ctrl.pop      = pop_any;
                    tt_wr.slice_we  = 1'b1;
                    tt_wr.run_we    = (cur_task_reg != rrs_pkg::IDLE_ID) && !requeue;
                    tt_wr.run_val   = 1'b0;
                    tt_wr.id        = cur_task_reg;
                    tt_wr.slice_val = wb_slice;
                    cur_task_next   = pick_task;
                    cur_slice_next  = (pick_task == cur_task_reg) ? wb_slice : tt_rd_slice;
                    switched        = pick_task != cur_task_reg;
                end
                rrs_pkg::OP_WAKE:
                begin
                    if (wake_ok)
                    begin
                        q_ctrl.push     = 1'b1;
                        q_ctrl.push_id  = s1_tid_reg;
                        tt_wr.slice_we  = 1'b1;
                        tt_wr.run_we    = 1'b1;
                        tt_wr.run_val   = 1'b1;
                        tt_wr.id        = s1_tid_reg;
                        tt_wr.slice_val = rrs_pkg::refill(tt_rd_slice, max_slice_reg);
                    end
                    else
                    begin
                        ignored = 1'b1;
                    end
                end
                default:
                begin
                    ignored = 1'b0;
                end
            endcase
        end
        count_next = q_stat.count + rrs_pkg::Q_PTR_W'(q_ctrl.push)
                     - rrs_pkg::Q_PTR_W'(q_ctrl.pop);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_task_reg  <= rrs_pkg::IDLE_ID;
            cur_slice_reg <= '0;
            resched_reg   <= 1'b0;
            max_slice_reg <= rrs_pkg::MAX_SLICE_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cur_task_reg  <= cur_task_next;
            cur_slice_reg <= cur_slice_next;
            resched_reg   <= resched_next;
            if (cfg.valid && cfg.ready)
            begin
                max_slice_reg <= cfg.max_slice;
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg    <= req.op;
            s1_tid_reg   <= req.task_id;
            s1_stays_reg <= req.current_stays_runnable;
        end
        if (adv)
        begin
            out_task_reg     <= cur_task_next;
            out_switched_reg <= switched;
            out_resched_reg  <= resched_next;
            out_slice_reg    <= cur_slice_next;
            out_count_reg    <= count_next;
            out_ignored_reg  <= ignored;
        end
    end

    // result channel
    assign rsp.valid           = out_valid_reg;
    assign rsp.running_task    = out_task_reg;
    assign rsp.switched        = out_switched_reg;
    assign rsp.resched_needed  = out_resched_reg;
    assign rsp.slice_remaining = out_slice_reg;
    assign rsp.ready_count     = out_count_reg;
    assign rsp.wake_ignored    = out_ignored_reg;

    `RRS_ASSERT(a_switch_only_sched,
                (adv && (s1_op_reg != rrs_pkg::OP_SCHED)) |=> !out_switched_reg,
                "switch reported outside schedule")
    `RRS_ASSERT(a_idle_no_slice,
                (cur_task_reg == rrs_pkg::IDLE_ID) |-> (cur_slice_reg == '0),
                "idle task holds a slice")

endmodule
